// ----- rtl/bsba_pkg.sv -----
// shared types, constants and helpers for the backside bus arbiter
package bsba_pkg;

	localparam int AGE_BITS  = 32;
	localparam int CNT_W     = 8;
	localparam int DLC_W     = 32;
	localparam int BT_W      = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 8;
	localparam int IN_W      = 152;
	localparam int OUT_W     = 56;

	// bus direction and transfer class coding
	typedef enum logic [2:0] {
		DIR_IDLE       = 3'd0,
		DIR_IN_REPLY   = 3'd1,
		DIR_IN_REQUEST = 3'd2,
		DIR_REQUEST    = 3'd3,
		DIR_PREFETCH   = 3'd4,
		DIR_SNOOP      = 3'd5,
		DIR_REPLY      = 3'd6
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUS_TIME_DATA   = 2'd0,
		REG_BUS_TIME_NODATA = 2'd1,
		REG_FAST_MODE       = 2'd2,
		REG_FAST_EVICT_EN   = 2'd3
	} cfg_idx_t;

	// outbound queue bit positions
	localparam int Q_REQ = 0;
	localparam int Q_PF  = 1;
	localparam int Q_SN  = 2;
	localparam int Q_RP  = 3;

	// inbound flag bit positions
	localparam int IB_RP_FULL = 0;
	localparam int IB_RP_DATA = 1;
	localparam int IB_RQ_FULL = 2;
	localparam int IB_RQ_DATA = 3;

	typedef struct packed {
		logic [BT_W-1:0] bus_time_data;
		logic [BT_W-1:0] bus_time_nodata;
		logic            fast_mode;
		logic            fast_evict_enable;
	} cfg_t;

	typedef struct packed {
		dir_t             dir;
		logic [CNT_W-1:0] cnt;
		logic [DLC_W-1:0] dlcnt;
	} state_t;

	typedef struct packed {
		logic [3:0]          inbound_flags;
		logic [1:0]          controller_full;
		logic [3:0]          outbound_nonempty;
		logic [3:0]          outbound_head_data;
		logic [3:0]          outbound_ready;
		logic                snoop_head_evict;
		logic [AGE_BITS-1:0] request_age;
		logic [AGE_BITS-1:0] prefetch_age;
		logic [AGE_BITS-1:0] snoop_age;
		logic [AGE_BITS-1:0] reply_age;
	} item_t;

	typedef struct packed {
		dir_t             grant;
		dir_t             deliver;
		logic             deadlock_event;
		logic             fast_evict_sent;
		dir_t             bus_direction;
		logic [CNT_W-1:0] cycles_left;
		logic [DLC_W-1:0] deadlock_total;
	} result_t;

	// extra bus ticks for one transfer
	function automatic logic [CNT_W-1:0] xfer_time(cfg_t cfg, logic has_data);
		logic [BT_W-1:0] t;
		t = has_data ? cfg.bus_time_data : cfg.bus_time_nodata;
		if (cfg.fast_mode || t == '0)
			return '0;
		return CNT_W'(t - BT_W'(1));
	endfunction

endpackage

// ----- rtl/backside_bus_arbiter.sv -----
// backside bus arbiter top level: config registers, input and result registers, bus state
// a beat is held in the input register, then its result is registered in the result register once that is free
// throughput: one beat per cycle while m_tready holds, each beat is one bus tick evaluated in a single pass
// the result register frees in the same cycle it is taken, so s_tready follows m_tready
// async reset clears bus state, deadlock count, config to bus times 1 and both modes off
// reset also empties the input and result registers
module backside_bus_arbiter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bsba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsba_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// inbound_flags, controller_full, outbound_nonempty, outbound_head_data, outbound_ready,
	// snoop_head_evict, request_age, prefetch_age, snoop_age, reply_age, zero pad
	input  logic [bsba_pkg::IN_W-1:0]      s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// grant, deliver, deadlock_event, fast_evict_sent, bus_direction, cycles_left,
	// deadlock_total, zero pad
	output logic [bsba_pkg::OUT_W-1:0]     m_tdata
);

	bsba_pkg::cfg_t    cfg_q;
	bsba_pkg::state_t  st_q;
	bsba_pkg::state_t  nxt;
	bsba_pkg::result_t res;
	bsba_pkg::item_t   item;
	logic [bsba_pkg::IN_W-1:0]  data_s1;
	logic                       valid_s1;
	logic [bsba_pkg::OUT_W-1:0] out_q;
	logic                       out_valid_q;
	logic                       advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	assign item.inbound_flags      = data_s1[3:0];
	assign item.controller_full    = data_s1[5:4];
	assign item.outbound_nonempty  = data_s1[9:6];
	assign item.outbound_head_data = data_s1[13:10];
	assign item.outbound_ready     = data_s1[17:14];
	assign item.snoop_head_evict   = data_s1[18];
	assign item.request_age        = data_s1[50:19];
	assign item.prefetch_age       = data_s1[82:51];
	assign item.snoop_age          = data_s1[114:83];
	assign item.reply_age          = data_s1[146:115];

	bsba_step u_step (
		.cfg  (cfg_q),
		.st   (st_q),
		.item (item),
		.nxt  (nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bus_time_data     <= bsba_pkg::BT_W'(1);
			cfg_q.bus_time_nodata   <= bsba_pkg::BT_W'(1);
			cfg_q.fast_mode         <= 1'b0;
			cfg_q.fast_evict_enable <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bsba_pkg::REG_BUS_TIME_DATA:   cfg_q.bus_time_data   <= cfg_data;
				bsba_pkg::REG_BUS_TIME_NODATA: cfg_q.bus_time_nodata <= cfg_data;
				bsba_pkg::REG_FAST_MODE:       cfg_q.fast_mode       <= cfg_data[0];
				bsba_pkg::REG_FAST_EVICT_EN:   cfg_q.fast_evict_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			st_q.dir    <= bsba_pkg::DIR_IDLE;
			st_q.cnt    <= '0;
			st_q.dlcnt  <= '0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance) begin
				st_q        <= nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			data_s1 <= s_tdata;
		if (advance)
			out_q <= {5'b0, res.deadlock_total, res.cycles_left, res.bus_direction,
				res.fast_evict_sent, res.deadlock_event, res.deliver, res.grant};
	end

	// a pending countdown always belongs to a transfer on the bus
	a_cnt_has_dir: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.cnt != '0 |-> st_q.dir != bsba_pkg::DIR_IDLE)
		else $error("countdown running with bus idle");

	// a transfer only starts from an idle bus with no countdown
	a_grant_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.grant != bsba_pkg::DIR_IDLE |->
			st_q.dir == bsba_pkg::DIR_IDLE && st_q.cnt == '0)
		else $error("grant while bus busy");

	// deadlock and delivery never come from the same completion
	a_dl_no_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.deadlock_event |-> res.deliver == bsba_pkg::DIR_IDLE)
		else $error("deadlock beat also delivered");

	// each deadlock beat bumps the running count by exactly one
	a_dl_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.deadlock_event |=> st_q.dlcnt == $past(st_q.dlcnt) + 32'd1)
		else $error("deadlock count off");

	// bus state only moves when a beat is evaluated
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(st_q.dir) && $stable(st_q.cnt) && $stable(st_q.dlcnt))
		else $error("bus state changed without a beat");

endmodule

// ----- rtl/bsba_step.sv -----
// one tick of arbitration, countdown and completion handling
module bsba_step (
	input  bsba_pkg::cfg_t    cfg,
	input  bsba_pkg::state_t  st,
	input  bsba_pkg::item_t   item,
	output bsba_pkg::state_t  nxt,
	output bsba_pkg::result_t res
);

	always_comb begin
		logic [3:0]     ne;
		logic [3:0]     rdy;
		logic [3:0]     hd;
		logic           sn_ne;
		logic           rp_ne;
		logic           fast;
		logic           dl_ev;
		logic [1:0]     q;
		bsba_pkg::dir_t g;
		bsba_pkg::dir_t dlv;

		ne    = item.outbound_nonempty;
		rdy   = item.outbound_ready;
		hd    = item.outbound_head_data;
		nxt   = st;
		g     = bsba_pkg::DIR_IDLE;
		dlv   = bsba_pkg::DIR_IDLE;
		dl_ev = 1'b0;
		q     = 2'(bsba_pkg::Q_REQ);

		// fast evict path hides the snoop head from this tick's arbitration
		fast = cfg.fast_evict_enable && st.dir == bsba_pkg::DIR_IDLE &&
			ne[bsba_pkg::Q_SN] && rdy[bsba_pkg::Q_SN] && item.snoop_head_evict;
		if (fast)
			ne[bsba_pkg::Q_SN] = 1'b0;
		sn_ne = ne[bsba_pkg::Q_SN];
		rp_ne = ne[bsba_pkg::Q_RP];

		if (st.cnt != '0) begin
			nxt.cnt = st.cnt - bsba_pkg::CNT_W'(1);
		end else if (st.dir == bsba_pkg::DIR_IDLE) begin
			if (item.inbound_flags[bsba_pkg::IB_RP_FULL] && !item.controller_full[0]) begin
				g       = bsba_pkg::DIR_IN_REPLY;
				nxt.cnt = bsba_pkg::xfer_time(cfg, item.inbound_flags[bsba_pkg::IB_RP_DATA]);
			end else if (item.inbound_flags[bsba_pkg::IB_RQ_FULL] &&
					!item.controller_full[1]) begin
				g       = bsba_pkg::DIR_IN_REQUEST;
				nxt.cnt = bsba_pkg::xfer_time(cfg, item.inbound_flags[bsba_pkg::IB_RQ_DATA]);
			end else if (ne[bsba_pkg::Q_REQ] && rdy[bsba_pkg::Q_REQ] &&
					(!sn_ne || item.snoop_age > item.request_age) &&
					(!rp_ne || item.reply_age > item.request_age)) begin
				g       = bsba_pkg::DIR_REQUEST;
				nxt.cnt = bsba_pkg::xfer_time(cfg, hd[bsba_pkg::Q_REQ]);
			end else if (!ne[bsba_pkg::Q_REQ] && ne[bsba_pkg::Q_PF] && rdy[bsba_pkg::Q_PF] &&
					(!sn_ne || item.snoop_age > item.prefetch_age) &&
					(!rp_ne || item.reply_age > item.prefetch_age)) begin
				g       = bsba_pkg::DIR_PREFETCH;
				nxt.cnt = bsba_pkg::xfer_time(cfg, hd[bsba_pkg::Q_PF]);
			end else if (sn_ne && rdy[bsba_pkg::Q_SN] &&
					(!rp_ne || item.reply_age > item.snoop_age)) begin
				g       = bsba_pkg::DIR_SNOOP;
				nxt.cnt = bsba_pkg::xfer_time(cfg, hd[bsba_pkg::Q_SN]);
			end else if (rp_ne && rdy[bsba_pkg::Q_RP]) begin
				g       = bsba_pkg::DIR_REPLY;
				nxt.cnt = bsba_pkg::xfer_time(cfg, hd[bsba_pkg::Q_RP]);
			end
			if (g != bsba_pkg::DIR_IDLE)
				nxt.dir = g;
		end

		// completion
		if (nxt.cnt == '0 && nxt.dir != bsba_pkg::DIR_IDLE) begin
			case (nxt.dir)
				bsba_pkg::DIR_IN_REPLY: begin
					if (!item.controller_full[0]) begin
						dlv     = nxt.dir;
						nxt.dir = bsba_pkg::DIR_IDLE;
					end
				end
				bsba_pkg::DIR_IN_REQUEST: begin
					if (!item.controller_full[1]) begin
						dlv     = nxt.dir;
						nxt.dir = bsba_pkg::DIR_IDLE;
					end
				end
				default: begin
					case (nxt.dir)
						bsba_pkg::DIR_PREFETCH: q = 2'(bsba_pkg::Q_PF);
						bsba_pkg::DIR_SNOOP:    q = 2'(bsba_pkg::Q_SN);
						bsba_pkg::DIR_REPLY:    q = 2'(bsba_pkg::Q_RP);
						default:                q = 2'(bsba_pkg::Q_REQ);
					endcase
					// empty queue at completion aborts quietly
					if (ne[q] && rdy[q]) begin
						dlv = nxt.dir;
					end else if (ne[q]) begin
						dl_ev     = 1'b1;
						nxt.dlcnt = st.dlcnt + bsba_pkg::DLC_W'(1);
					end
					nxt.dir = bsba_pkg::DIR_IDLE;
				end
			endcase
		end

		res.grant           = g;
		res.deliver         = dlv;
		res.deadlock_event  = dl_ev;
		res.fast_evict_sent = fast;
		res.bus_direction   = nxt.dir;
		res.cycles_left     = nxt.cnt;
		res.deadlock_total  = nxt.dlcnt;
	end

endmodule

// ----- dv/tb.sv -----
// testbench for the backside bus arbiter: self-checking stream test with a cycle-level predictor
`timescale 1ns / 1ps

module tb;
	import bsba_pkg::*;

	localparam int STUCK_LIMIT = 4000;

	// one bus tick, declared highest field first so the bit layout matches s_tdata
	typedef struct packed {
		logic [AGE_BITS-1:0] reply_age;
		logic [AGE_BITS-1:0] snoop_age;
		logic [AGE_BITS-1:0] prefetch_age;
		logic [AGE_BITS-1:0] request_age;
		logic                evict;
		logic [3:0]          rdy;
		logic [3:0]          hd;
		logic [3:0]          ne;
		logic [1:0]          cfull;
		logic [3:0]          inb;
	} tick_t;

	// one bus status beat, declared highest field first so the bit layout matches m_tdata
	typedef struct packed {
		logic [DLC_W-1:0] deadlock_total;
		logic [CNT_W-1:0] cycles_left;
		dir_t             bus_direction;
		logic             fast_evict_sent;
		logic             deadlock_event;
		dir_t             deliver;
		dir_t             grant;
	} bus_out_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// inbound_flags, controller_full, outbound_nonempty, outbound_head_data, outbound_ready,
	// snoop_head_evict, request_age, prefetch_age, snoop_age, reply_age, zero pad
	logic [IN_W-1:0]      s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// grant, deliver, deadlock_event, fast_evict_sent, bus_direction, cycles_left,
	// deadlock_total, zero pad
	logic [OUT_W-1:0]     m_tdata;

	// predictor copy of the registers and bus state
	logic [BT_W-1:0]  bt_data = 8'd1;
	logic [BT_W-1:0]  bt_nodata = 8'd1;
	logic             fast_on = 1'b0;
	logic             fe_on = 1'b0;
	dir_t             bus_dir = DIR_IDLE;
	logic [CNT_W-1:0] bus_cnt = '0;
	logic [DLC_W-1:0] dl_count = '0;

	tick_t    tick_queue[$];
	bus_out_t bus_out_due[$];
	int       ticks_taken = 0;
	int       mismatches = 0;
	int       stuck_cycles = 0;
	int       tx_idle_pct;
	int       rx_stall_pct;

	backside_bus_arbiter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// idling schedule follows progress through the run
	always_comb begin
		if (ticks_taken < 150) begin
			tx_idle_pct = 37;
			rx_stall_pct = 80;
		end else if (ticks_taken < 300) begin
			tx_idle_pct = 80;
			rx_stall_pct = 37;
		end else begin
			tx_idle_pct = 0;
			rx_stall_pct = 0;
		end
	end

	function automatic logic [CNT_W-1:0] extra_ticks(logic has_data);
		logic [BT_W-1:0] bt;
		bt = has_data ? bt_data : bt_nodata;
		if (fast_on || bt == '0)
			return '0;
		return bt - 8'd1;
	endfunction

	// advances the predicted bus by one tick and returns its status beat
	function automatic bus_out_t arbitrate_tick(tick_t t);
		bus_out_t r;
		logic [3:0] ne;
		logic sn_ne, rp_ne;
		dir_t g;
		int q;
		r = '0;
		ne = t.ne;
		g = DIR_IDLE;
		if (fe_on && bus_dir == DIR_IDLE && ne[Q_SN] && t.rdy[Q_SN] && t.evict) begin
			r.fast_evict_sent = 1'b1;
			ne[Q_SN] = 1'b0;
		end
		sn_ne = ne[Q_SN];
		rp_ne = ne[Q_RP];
		if (bus_cnt != '0) begin
			bus_cnt = bus_cnt - 8'd1;
		end else if (bus_dir == DIR_IDLE) begin
			if (t.inb[IB_RP_FULL] && !t.cfull[0]) begin
				g = DIR_IN_REPLY;
				bus_cnt = extra_ticks(t.inb[IB_RP_DATA]);
			end else if (t.inb[IB_RQ_FULL] && !t.cfull[1]) begin
				g = DIR_IN_REQUEST;
				bus_cnt = extra_ticks(t.inb[IB_RQ_DATA]);
			end else if (ne[Q_REQ] && t.rdy[Q_REQ] && (!sn_ne || t.snoop_age > t.request_age)
					&& (!rp_ne || t.reply_age > t.request_age)) begin
				g = DIR_REQUEST;
				bus_cnt = extra_ticks(t.hd[Q_REQ]);
			end else if (!ne[Q_REQ] && ne[Q_PF] && t.rdy[Q_PF]
					&& (!sn_ne || t.snoop_age > t.prefetch_age)
					&& (!rp_ne || t.reply_age > t.prefetch_age)) begin
				g = DIR_PREFETCH;
				bus_cnt = extra_ticks(t.hd[Q_PF]);
			end else if (sn_ne && t.rdy[Q_SN] && (!rp_ne || t.reply_age > t.snoop_age)) begin
				g = DIR_SNOOP;
				bus_cnt = extra_ticks(t.hd[Q_SN]);
			end else if (rp_ne && t.rdy[Q_RP]) begin
				g = DIR_REPLY;
				bus_cnt = extra_ticks(t.hd[Q_RP]);
			end
			if (g != DIR_IDLE)
				bus_dir = g;
		end
		r.grant = g;
		if (bus_cnt == '0 && bus_dir != DIR_IDLE) begin
			if (bus_dir == DIR_IN_REPLY || bus_dir == DIR_IN_REQUEST) begin
				// inbound waits while the controller queue is full
				if (!t.cfull[(bus_dir == DIR_IN_REPLY) ? 0 : 1]) begin
					r.deliver = bus_dir;
					bus_dir = DIR_IDLE;
				end
			end else begin
				q = int'(bus_dir) - int'(DIR_REQUEST);
				if (ne[q] && t.rdy[q]) begin
					r.deliver = bus_dir;
				end else if (ne[q]) begin
					r.deadlock_event = 1'b1;
					dl_count = dl_count + 32'd1;
				end
				bus_dir = DIR_IDLE;
			end
		end
		r.bus_direction = bus_dir;
		r.cycles_left = bus_cnt;
		r.deadlock_total = dl_count;
		return r;
	endfunction

	function automatic tick_t mk_tick(logic [3:0] inb, logic [1:0] cfull, logic [3:0] ne,
			logic [3:0] hd, logic [3:0] rdy, logic ev, logic [31:0] ra, logic [31:0] pa,
			logic [31:0] sa, logic [31:0] rpa);
		tick_t t;
		t.inb = inb;
		t.cfull = cfull;
		t.ne = ne;
		t.hd = hd;
		t.rdy = rdy;
		t.evict = ev;
		t.request_age = ra;
		t.prefetch_age = pa;
		t.snoop_age = sa;
		t.reply_age = rpa;
		return t;
	endfunction

	// appends one tick to the pending list
	task automatic queue_tick(tick_t t);
		tick_queue.insert(tick_queue.size(), t);
	endtask

	// mostly small ages so ties and near ties are common
	function automatic logic [AGE_BITS-1:0] pick_age();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return $urandom;
			default: return $urandom_range(0, 5);
		endcase
	endfunction

	// driver: offers the next queued tick once the current beat is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (tick_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				s_tdata <= IN_W'(tick_queue[0]);
				tick_queue.delete(0);
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			bus_out_due.insert(bus_out_due.size(),
				arbitrate_tick(tick_t'(s_tdata[$bits(tick_t)-1:0])));
			ticks_taken++;
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0h, got %0h", name, want, got);
		end
	endtask

	// monitor: compares each status beat with the oldest prediction
	always @(posedge clk) begin : monitor
		bus_out_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = bus_out_t'(m_tdata[$bits(bus_out_t)-1:0]);
			if (bus_out_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: got %0h", got);
			end else begin
				want = bus_out_due[0];
				bus_out_due.delete(0);
				check_field("grant", want.grant, got.grant);
				check_field("deliver", want.deliver, got.deliver);
				check_field("deadlock_event", want.deadlock_event, got.deadlock_event);
				check_field("fast_evict_sent", want.fast_evict_sent, got.fast_evict_sent);
				check_field("bus_direction", want.bus_direction, got.bus_direction);
				check_field("cycles_left", want.cycles_left, got.cycles_left);
				check_field("deadlock_total", want.deadlock_total, got.deadlock_total);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	task automatic wait_idle();
		while (tick_queue.size() != 0 || s_tvalid || bus_out_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BUS_TIME_DATA: bt_data = val;
			REG_BUS_TIME_NODATA: bt_nodata = val;
			REG_FAST_MODE: fast_on = val[0];
			REG_FAST_EVICT_EN: fe_on = val[0];
			default: ;
		endcase
	endtask

	task automatic run_phase(logic [7:0] bt_d, logic [7:0] bt_nd, logic fast, logic fe, int n);
		tick_t t;
		wait_idle();
		write_reg(REG_BUS_TIME_DATA, bt_d);
		write_reg(REG_BUS_TIME_NODATA, bt_nd);
		write_reg(REG_FAST_MODE, CFG_W'(fast));
		write_reg(REG_FAST_EVICT_EN, CFG_W'(fe));
		for (int k = 0; k < n; k++) begin
			// inbound mostly quiet so the outbound classes get the bus
			t.inb = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0;
			t.cfull = ($urandom_range(0, 2) == 0) ? 2'($urandom) : 2'b00;
			t.ne = 4'($urandom);
			t.hd = 4'($urandom);
			t.rdy = ($urandom_range(0, 1) == 0) ? 4'hf : 4'($urandom);
			t.evict = 1'($urandom);
			t.request_age = pick_age();
			t.prefetch_age = pick_age();
			t.snoop_age = pick_age();
			t.reply_age = pick_age();
			queue_tick(t);
		end
	endtask

	initial begin
		// arbitration order and age ties at bus time 1
		queue_tick(mk_tick(4'h0, 2'b00, 4'h0, 4'h0, 4'h0, 1'b0, 0, 0, 0, 0));
		queue_tick(mk_tick(4'h1, 2'b00, 4'h0, 4'h0, 4'h0, 1'b0, 0, 0, 0, 0));
		queue_tick(mk_tick(4'hc, 2'b00, 4'h0, 4'h0, 4'h0, 1'b0, 0, 0, 0, 0));
		queue_tick(mk_tick(4'h5, 2'b01, 4'h0, 4'h0, 4'h0, 1'b0, 0, 0, 0, 0));
		queue_tick(mk_tick(4'hf, 2'b11, 4'hf, 4'hf, 4'hf, 1'b1, 0, 0, 0, 0));
		queue_tick(mk_tick(4'h0, 2'b00, 4'h1, 4'h1, 4'h1, 1'b0, '1, '1, '1, '1));
		queue_tick(mk_tick(4'h0, 2'b00, 4'hf, 4'hf, 4'hf, 1'b0, 0, '1, '1, '1));
		queue_tick(mk_tick(4'h0, 2'b00, 4'hf, 4'h0, 4'hf, 1'b0, 5, 0, 5, '1));
		queue_tick(mk_tick(4'h0, 2'b00, 4'he, 4'he, 4'he, 1'b0, 0, 1, 2, 3));
		queue_tick(mk_tick(4'h0, 2'b00, 4'h8, 4'h8, 4'h8, 1'b1, 0, 0, 0, 0));
		queue_tick(mk_tick(4'h0, 2'b00, 4'h8, 4'h0, 4'h0, 1'b0, 0, 0, 0, 0));
		queue_tick(mk_tick(4'h0, 2'b00, 4'h1, 4'h0, 4'he, 1'b0, 0, 0, 0, 0));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// deadlock, empty queue at completion, fast evict, controller full hold
		wait_idle();
		write_reg(REG_BUS_TIME_DATA, 8'd2);
		write_reg(REG_BUS_TIME_NODATA, 8'd2);
		write_reg(REG_FAST_EVICT_EN, 8'd1);
		queue_tick(mk_tick(4'h0, 2'b00, 4'h1, 4'h0, 4'h1, 1'b0, 0, 0, 0, 0));
		queue_tick(mk_tick(4'h0, 2'b00, 4'h1, 4'h0, 4'h0, 1'b0, 0, 0, 0, 0));
		queue_tick(mk_tick(4'h0, 2'b00, 4'h1, 4'h1, 4'h1, 1'b0, 0, 0, 0, 0));
		queue_tick(mk_tick(4'h0, 2'b00, 4'h0, 4'h0, 4'h1, 1'b0, 0, 0, 0, 0));
		queue_tick(mk_tick(4'h0, 2'b00, 4'h4, 4'h0, 4'h4, 1'b1, 0, 0, 0, 0));
		queue_tick(mk_tick(4'h0, 2'b00, 4'hc, 4'h0, 4'hc, 1'b1, 0, 0, 0, 5));
		queue_tick(mk_tick(4'h0, 2'b00, 4'hc, 4'h0, 4'hc, 1'b1, 0, 0, 0, 5));
		queue_tick(mk_tick(4'h3, 2'b00, 4'h0, 4'h0, 4'h0, 1'b0, 0, 0, 0, 0));
		queue_tick(mk_tick(4'h3, 2'b01, 4'h0, 4'h0, 4'h0, 1'b0, 0, 0, 0, 0));
		queue_tick(mk_tick(4'h0, 2'b00, 4'h0, 4'h0, 4'h0, 1'b0, 0, 0, 0, 0));

		run_phase(8'd3, 8'd2, 1'b0, 1'b1, 75);
		run_phase(8'd255, 8'd255, 1'b0, 1'b0, 75);
		// a bus time of zero behaves like one
		run_phase(8'd0, 8'd1, 1'b0, 1'b1, 75);
		run_phase(8'd200, 8'd5, 1'b1, 1'b1, 75);
		run_phase(8'd1, 8'd4, 1'b0, 1'b0, 75);
		run_phase(8'd7, 8'd0, 1'b1, 1'b0, 75);

		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
